@@ rtl/twg_pkg.sv @@
// shared types and constants of the taper window gate
package twg_pkg;

    localparam int DISP_W       = 20;
    localparam int DISP_TDATA_W = 24;
    localparam int WGT_W        = 17;
    localparam int IDX_W        = 20;
    localparam int INV_W        = 25;
    localparam int CNT_W        = 21;
    localparam int SUM_W        = 41;
    localparam int SQ_W         = 59;
    localparam int ERR_W        = 2;
    localparam int OUT_TDATA_W  = 200;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 25;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 64;
    localparam int Q_BITS       = 24;
    localparam int X_W          = 24;
    localparam int X2_W         = 23;
    localparam int X3_W         = 22;
    localparam int P_W          = 29;
    localparam int DIV_W        = 60;
    localparam int SQRT_W       = 40;
    localparam int ROOT_W       = 20;
    localparam int REM_W        = 24;
    localparam int STEP_W       = 6;

    localparam int DEF_MAX_SAMPLES = 1048576;
    localparam int DEF_SAMPLE_BITS = 20;
    localparam int DEF_WFB         = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PLACE_START = 3'd0,
        CFG_FULL_START  = 3'd1,
        CFG_FULL_END    = 3'd2,
        CFG_PLACE_END   = 3'd3,
        CFG_FADE_IN     = 3'd4,
        CFG_FADE_OUT    = 3'd5
    } t_cfg_reg;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_FULL_EMPTY = 2'd1,
        ERR_OVERFLOW   = 2'd2
    } t_err;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_iter_op;

    typedef enum logic [4:0] {
        S_IDLE, S_TMUL, S_TCHK, S_X2, S_X3, S_LQ, S_WT, S_GATE, S_GSQ,
        S_ACC, S_FACC, S_MEAN_GO, S_MEAN_WAIT, S_MSQ_GO, S_MSQ_WAIT,
        S_RT_GO, S_RT_WAIT, S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        t_iter_op         op;
        logic [DIV_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_iter_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic             rem_nz;
    } t_iter_rsp;

endpackage

@@ rtl/twg_iter.sv @@
// bit-serial divider and integer square root sharing one shift datapath
module twg_iter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twg_pkg::t_iter_req  i_req,
    output twg_pkg::t_iter_rsp  o_rsp
);
    import twg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_iter_op          r_op;
    logic [CNT_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0]  div_s;
    logic [REM_W-1:0]  sq_s;
    logic [REM_W-1:0]  trial;
    logic              div_ge;
    logic              sq_ge;

    always_comb begin
        div_s  = {r_rem[REM_W-2:0], r_acc[DIV_W-1]};
        sq_s   = {r_rem[REM_W-3:0], r_acc[DIV_W-1:DIV_W-2]};
        trial  = {2'b00, r_root, 2'b01};
        div_ge = div_s >= REM_W'(r_den);
        sq_ge  = sq_s >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == OP_DIV) ? STEP_W'(DIV_W) : STEP_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_root <= '0;
            if (i_req.op == OP_DIV) begin
                r_acc <= i_req.num;
            end else begin
                r_acc <= i_req.num << (DIV_W - SQRT_W);
            end
        end else if (r_busy) begin
            unique case (r_op)
                OP_DIV: begin
                    r_rem <= div_ge ? div_s - REM_W'(r_den) : div_s;
                    r_acc <= {r_acc[DIV_W-2:0], div_ge};
                end
                OP_SQRT: begin
                    r_rem  <= sq_ge ? sq_s - trial : sq_s;
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_acc  <= r_acc << 2;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = (r_op == OP_DIV) ? r_acc : DIV_W'(r_root);
    assign o_rsp.rem_nz = (r_rem != '0);

endmodule

@@ rtl/taper_window_gate_with_statistics.sv @@
// taper window gate: quintic fade weight, gated sample and profile statistics
//
// Input channel (i_s_*): one displacement sample per station, tlast on the
// final station of a profile. Stations are numbered internally from zero.
// Output channel (o_m_*): one result per input item: gated sample and weight,
// and on the item carrying tlast also counts, means, rms and peaks of the
// full-amplitude set and of the whole profile (o_m_tlast set, o_m_tuser the
// error code). Registers are written through i_cfg_* while the block is idle;
// the user must keep to this, as the block has no check of its own. One item
// at a time passes a sequencer around a single 32x32 multiplier. An item with
// weight 0 or 1 runs S_GATE through S_DONE into the output register; in a fade
// S_TMUL and S_TCHK come first, then S_X2 to S_WT unless the fraction is zero
// or saturates. The input is ready again when the result is loaded. The last
// item of a profile adds per set one 60-step division for the mean, one for
// the mean square and a 20-step square root, all in the bit-serial unit.
// The output register parts the two sides: the next item is taken while a
// result waits; a stalled receiver holds only the following result.
// Reset clears the registers to their defaults, the station counter and all
// sums; the statistics clear again after each last item.
module taper_window_gate_with_statistics #(
    parameter int MAX_SAMPLES          = twg_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS          = twg_pkg::DEF_SAMPLE_BITS,
    parameter int WEIGHT_FRACTION_BITS = twg_pkg::DEF_WFB
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [twg_pkg::DISP_TDATA_W-1:0]    i_s_tdata,   // displacement
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // gated_displacement, weight, full_count, full_mean, full_rms, full_peak,
    // all_count, all_mean, all_rms, all_peak
    output logic [twg_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,   // stats_valid
    output logic [twg_pkg::ERR_W-1:0]           o_m_tuser,   // error_code
    input  logic                                i_cfg_we,
    input  logic [twg_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [twg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import twg_pkg::*;

    localparam logic [WGT_W-1:0] W_ONE   = WGT_W'(1) << WEIGHT_FRACTION_BITS;
    localparam int               L_SHIFT = Q_BITS - WEIGHT_FRACTION_BITS;
    localparam int               GMAG_W  = DISP_W + WGT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // configuration
    logic [IDX_W-1:0] r_ps, r_fs, r_fe, r_pe;
    logic [INV_W-1:0] r_fin, r_fout;

    // sequencer and item datapath
    t_state              r_state, n_state;
    logic [PROD_W-1:0]   r_prod;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic signed [DISP_W-1:0] r_d;
    logic                r_last;
    logic [IDX_W-1:0]    r_dist;
    logic [INV_W-1:0]    r_inv;
    logic [WGT_W-1:0]    r_w;
    logic [X_W-1:0]      r_x;
    logic [X2_W-1:0]     r_x2;
    logic                r_hi;
    logic signed [DISP_W-1:0] r_g;
    logic [DISP_W-1:0]   r_gmag;
    logic                r_pass;
    logic [SQRT_W-1:0]   r_msq;

    // statistics
    logic [CNT_W-1:0]    r_station;
    logic                r_ovf;
    logic [CNT_W-1:0]    r_acnt, r_fcnt;
    logic signed [SUM_W-1:0] r_asum, r_fsum;
    logic [SQ_W-1:0]     r_asq, r_fsq;
    logic [DISP_W-1:0]   r_apk, r_fpk;
    logic [DISP_W-1:0]   r_fmean, r_frms, r_amean, r_arms;

    // output register
    logic                r_ovalid;
    logic [DISP_W-1:0]   r_og;
    logic [WGT_W-1:0]    r_ow;
    logic                r_olast;
    logic [ERR_W-1:0]    r_oerr;
    logic [CNT_W-1:0]    r_ofcnt, r_oacnt;
    logic [DISP_W-1:0]   r_ofmean, r_ofrms, r_ofpk, r_oamean, r_oarms, r_oapk;

    t_iter_req           iter_req;
    t_iter_rsp           iter_rsp;

    // combinational helpers
    logic signed [DISP_W-1:0] d_in;
    logic [CNT_W-1:0]    idx;
    logic                in_zero, in_fadein, in_fadeout;
    logic [DISP_W-1:0]   dmag;
    logic [P_W-1:0]      poly;
    logic [X_W-1:0]      lq;
    logic [WGT_W-1:0]    lw;
    logic [GMAG_W-1:0]   pmag;
    logic [DISP_W-1:0]   gmag;
    logic                in_full;
    logic                counting;
    logic                out_free;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]    sel_sum_mag;
    logic [CNT_W-1:0]    sel_cnt;
    logic [SQ_W-1:0]     sel_sq;
    logic [DISP_W-1:0]   mean_mag;

    always_comb begin
        d_in = $signed(i_s_tdata[DISP_W-1:0] << (DISP_W - SAMPLE_BITS))
               >>> (DISP_W - SAMPLE_BITS);
        idx        = r_station;
        in_zero    = (idx <= CNT_W'(r_ps)) || (idx >= CNT_W'(r_pe));
        in_fadein  = idx < CNT_W'(r_fs);
        in_fadeout = idx > CNT_W'(r_fe);
        dmag       = r_d[DISP_W-1] ? DISP_W'(-r_d) : DISP_W'(r_d);
        poly = P_W'(10) * (P_W'(1) << Q_BITS) - (P_W'(r_x) << 4) + P_W'(r_x)
               + (P_W'(r_x2) << 2) + (P_W'(r_x2) << 1);
        lq   = r_prod[Q_BITS+X_W-1:Q_BITS];
        lw   = WGT_W'(lq >> L_SHIFT);
        pmag = r_prod[GMAG_W-1:0];
        gmag = r_d[DISP_W-1]
             ? DISP_W'((pmag + GMAG_W'(W_ONE - WGT_W'(1))) >> WEIGHT_FRACTION_BITS)
             : DISP_W'(pmag >> WEIGHT_FRACTION_BITS);
        in_full  = (idx >= CNT_W'(r_fs)) && (idx <= CNT_W'(r_fe));
        counting = idx < CNT_MAX;
        out_free = !r_ovalid || i_m_tready;
        sel_sum  = r_pass ? r_asum : r_fsum;
        sel_cnt  = r_pass ? r_acnt : r_fcnt;
        sel_sq   = r_pass ? r_asq : r_fsq;
        sel_sum_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
        mean_mag = DISP_W'(iter_rsp.quo) + DISP_W'(iter_rsp.rem_nz);
    end

    // next state, multiplier operands and requests to the serial unit
    always_comb begin
        n_state  = r_state;
        mul_a    = '0;
        mul_b    = '0;
        iter_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (!in_zero && (in_fadein || in_fadeout)) ? S_TMUL : S_GATE;
                end
            end
            S_TMUL: begin
                mul_a   = MUL_W'(r_dist);
                mul_b   = MUL_W'(r_inv);
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (r_prod >= (PROD_W'(1) << Q_BITS) || r_prod == '0) begin
                    n_state = S_GATE;
                end else begin
                    n_state = S_X2;
                end
            end
            S_X2: begin
                mul_a   = MUL_W'(r_x);
                mul_b   = MUL_W'(r_x);
                n_state = S_X3;
            end
            S_X3: begin
                mul_a   = MUL_W'(r_prod[Q_BITS+X2_W-1:Q_BITS]);
                mul_b   = MUL_W'(r_x);
                n_state = S_LQ;
            end
            S_LQ: begin
                mul_a   = MUL_W'(r_prod[Q_BITS+X3_W-1:Q_BITS]);
                mul_b   = MUL_W'(poly);
                n_state = S_WT;
            end
            S_WT: begin
                n_state = S_GATE;
            end
            S_GATE: begin
                mul_a   = MUL_W'(dmag);
                mul_b   = MUL_W'(r_w);
                n_state = S_GSQ;
            end
            S_GSQ: begin
                mul_a   = MUL_W'(gmag);
                mul_b   = MUL_W'(gmag);
                n_state = S_ACC;
            end
            S_ACC: begin
                mul_a   = MUL_W'(dmag);
                mul_b   = MUL_W'(dmag);
                n_state = S_FACC;
            end
            S_FACC: begin
                n_state = r_last ? S_MEAN_GO : S_DONE;
            end
            S_MEAN_GO: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV;
                iter_req.num   = DIV_W'(sel_sum_mag);
                iter_req.den   = sel_cnt;
                n_state        = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (iter_rsp.done) begin
                    n_state = S_MSQ_GO;
                end
            end
            S_MSQ_GO: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV;
                iter_req.num   = DIV_W'(sel_sq);
                iter_req.den   = sel_cnt;
                n_state        = S_MSQ_WAIT;
            end
            S_MSQ_WAIT: begin
                if (iter_rsp.done) begin
                    n_state = S_RT_GO;
                end
            end
            S_RT_GO: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_SQRT;
                iter_req.num   = DIV_W'(r_msq);
                n_state        = S_RT_WAIT;
            end
            S_RT_WAIT: begin
                if (iter_rsp.done) begin
                    n_state = r_pass ? S_DONE : S_MEAN_GO;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps   <= '0;
            r_fs   <= '0;
            r_fe   <= '0;
            r_pe   <= '0;
            r_fin  <= INV_W'(1);
            r_fout <= INV_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PLACE_START: r_ps   <= i_cfg_data[IDX_W-1:0];
                CFG_FULL_START:  r_fs   <= i_cfg_data[IDX_W-1:0];
                CFG_FULL_END:    r_fe   <= i_cfg_data[IDX_W-1:0];
                CFG_PLACE_END:   r_pe   <= i_cfg_data[IDX_W-1:0];
                CFG_FADE_IN:     r_fin  <= i_cfg_data[INV_W-1:0];
                CFG_FADE_OUT:    r_fout <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier with registered product
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_d    <= d_in;
                r_last <= i_s_tlast;
                r_inv  <= in_fadein ? r_fin : r_fout;
                r_dist <= in_fadein ? IDX_W'(idx - CNT_W'(r_ps))
                                    : IDX_W'(CNT_W'(r_pe) - idx);
                r_w    <= in_zero ? '0 : W_ONE;
            end
            S_TCHK: begin
                if (r_prod >= (PROD_W'(1) << Q_BITS)) begin
                    r_w <= W_ONE;
                end else if (r_prod == '0) begin
                    r_w <= '0;
                end else begin
                    // upper half folds onto the lower half of the curve
                    r_hi <= r_prod[Q_BITS-1:0] > (X_W'(1) << (Q_BITS - 1));
                    r_x  <= (r_prod[Q_BITS-1:0] > (X_W'(1) << (Q_BITS - 1)))
                          ? X_W'(-r_prod[Q_BITS-1:0]) : r_prod[Q_BITS-1:0];
                end
            end
            S_X3: begin
                r_x2 <= r_prod[Q_BITS+X2_W-1:Q_BITS];
            end
            S_WT: begin
                r_w <= r_hi ? W_ONE - lw : lw;
            end
            S_GSQ: begin
                r_gmag <= gmag;
                r_g    <= r_d[DISP_W-1] ? -$signed(gmag) : $signed(gmag);
            end
            S_MEAN_WAIT: begin
                if (iter_rsp.done) begin
                    if (r_pass) begin
                        r_amean <= sel_sum[SUM_W-1] ? -mean_mag : DISP_W'(iter_rsp.quo);
                    end else begin
                        r_fmean <= sel_sum[SUM_W-1] ? -mean_mag : DISP_W'(iter_rsp.quo);
                    end
                end
            end
            S_MSQ_WAIT: begin
                if (iter_rsp.done) begin
                    r_msq <= iter_rsp.quo[SQRT_W-1:0];
                end
            end
            S_RT_WAIT: begin
                if (iter_rsp.done) begin
                    if (r_pass) begin
                        r_arms <= iter_rsp.quo[DISP_W-1:0];
                    end else begin
                        r_frms <= iter_rsp.quo[DISP_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // statistics and station counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= '0;
            r_ovf     <= 1'b0;
            r_pass    <= 1'b0;
            r_acnt    <= '0;
            r_asum    <= '0;
            r_asq     <= '0;
            r_apk     <= '0;
            r_fcnt    <= '0;
            r_fsum    <= '0;
            r_fsq     <= '0;
            r_fpk     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pass <= 1'b0;
                end
                S_ACC: begin
                    if (counting) begin
                        r_acnt <= r_acnt + CNT_W'(1);
                        r_asum <= r_asum + SUM_W'(r_g);
                        r_asq  <= r_asq + SQ_W'(r_prod);
                        if (r_gmag > r_apk) begin
                            r_apk <= r_gmag;
                        end
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                S_FACC: begin
                    if (counting) begin
                        r_station <= r_station + CNT_W'(1);
                        if (in_full) begin
                            r_fcnt <= r_fcnt + CNT_W'(1);
                            r_fsum <= r_fsum + SUM_W'(r_d);
                            r_fsq  <= r_fsq + SQ_W'(r_prod);
                            if (dmag > r_fpk) begin
                                r_fpk <= dmag;
                            end
                        end
                    end
                end
                S_RT_WAIT: begin
                    if (iter_rsp.done) begin
                        r_pass <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free && r_last) begin
                        r_station <= '0;
                        r_ovf     <= 1'b0;
                        r_acnt    <= '0;
                        r_asum    <= '0;
                        r_asq     <= '0;
                        r_apk     <= '0;
                        r_fcnt    <= '0;
                        r_fsum    <= '0;
                        r_fsq     <= '0;
                        r_fpk     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_og    <= r_g;
            r_ow    <= r_w;
            r_olast <= r_last;
            if (r_last) begin
                r_oerr   <= r_ovf ? ERR_OVERFLOW
                          : ((r_fcnt == '0) ? ERR_FULL_EMPTY : ERR_NONE);
                r_ofcnt  <= r_fcnt;
                r_ofmean <= (r_fcnt == '0) ? '0 : r_fmean;
                r_ofrms  <= (r_fcnt == '0) ? '0 : r_frms;
                r_ofpk   <= r_fpk;
                r_oacnt  <= r_acnt;
                r_oamean <= (r_acnt == '0) ? '0 : r_amean;
                r_oarms  <= (r_acnt == '0) ? '0 : r_arms;
                r_oapk   <= r_apk;
            end else begin
                r_oerr   <= ERR_NONE;
                r_ofcnt  <= '0;
                r_ofmean <= '0;
                r_ofrms  <= '0;
                r_ofpk   <= '0;
                r_oacnt  <= '0;
                r_oamean <= '0;
                r_oarms  <= '0;
                r_oapk   <= '0;
            end
        end
    end

    twg_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oerr;
    assign o_m_tdata  = {1'b0, r_oapk, r_oarms, r_oamean, r_oacnt,
                         r_ofpk, r_ofrms, r_ofmean, r_ofcnt, r_ow, r_og};

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ow <= W_ONE))
        else $error("weight above full amplitude");

    a_station_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_station <= CNT_MAX)
        else $error("station counter past limit");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_ofcnt == '0 && r_oacnt == '0 && r_oerr == ERR_NONE))
        else $error("statistics on a plain result");

    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_rsp.done |-> (r_state == S_MEAN_WAIT || r_state == S_MSQ_WAIT
                           || r_state == S_RT_WAIT))
        else $error("serial unit finished outside a wait step");

endmodule
